// ===== hw/rtl/sod_pkg.sv =====
// Shared types, widths and helpers of the sphere overlap displacement block.
package sod_pkg;

  localparam int MaxParticles = 64;
  localparam int IdxW   = $clog2(MaxParticles);
  localparam int CntW   = $clog2(MaxParticles + 1);
  localparam int PosW   = 16;
  localparam int RadW   = 15;
  localparam int GainW  = 24;
  localparam int OutW   = 32;
  localparam int D2W    = 32;
  localparam int S2W    = 34;
  localparam int RootW  = 16;
  localparam int NumW   = 56;
  localparam int DenW   = 34;
  localparam int AccW   = 63;

  localparam logic signed [OutW-1:0] GapInit = 32'sd65536000;

  typedef enum logic {
    REG_INFLATE = 1'b0,
    REG_GAIN    = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_I, ST_LD_I, ST_RD_J, ST_LD_J, ST_D2, ST_S2, ST_TEST,
    ST_SQRT, ST_GAP, ST_DIVQ, ST_MULP, ST_MULN, ST_DIVP, ST_MULF, ST_DIVF,
    ST_MULC, ST_DIVC, ST_EMIT
  } sod_state_e;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
    logic [RadW-1:0] r;
  } entry_t;

  typedef struct packed {
    logic            go;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic           go;
    logic [D2W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [OutW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sd2147483647);
    lo = -AccW'(64'sd2147483648);
    if (v > hi) begin
      return {1'b0, {(OutW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(OutW-1){1'b0}}};
    end
    return v[OutW-1:0];
  endfunction

endpackage

// ===== hw/rtl/sphere_overlap_displacement.sv =====
// Top level of the sphere overlap displacement block: particle store and pair sequencer.
//
// Particles are loaded one beat per cycle with start_i while busy_o is low; a beat with
// last_particle_i set starts the all-pairs pass over the stored particles, and busy_o falls
// in the cycle in which the last displacement is on the ports. Up to 64 particles are kept;
// further ones are dropped. For each particle the sequencer reads its partner from the
// single-port store and evaluates one ordered pair at a time: a pair that does not overlap
// goes through read, load, three squares, radius square and test; an overlapping pair adds
// a square root (16 steps plus start and finish) and a gap update and, unless both centres
// coincide, six divisions from the shared divider (56 steps plus start and finish) and six
// multiply steps. Each particle adds a self pair skip, a particle read and load, the end
// of its partner scan and a result. Results come out in load order, each one held for
// exactly one cycle with result_valid_o high; the receiver cannot stall them, and two
// results are never adjacent. min_half_gap_o is zero except on the beat with
// last_result_o set.
module sphere_overlap_displacement import sod_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [GainW-1:0]       cfg_data_i,
  input  logic                   start_i,
  input  logic [PosW-1:0]        pos_x_i,
  input  logic [PosW-1:0]        pos_y_i,
  input  logic [PosW-1:0]        pos_z_i,
  input  logic [RadW-1:0]        radius_i,
  input  logic                   last_particle_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output logic signed [OutW-1:0] disp_x_o,
  output logic signed [OutW-1:0] disp_y_o,
  output logic signed [OutW-1:0] disp_z_o,
  output logic signed [OutW-1:0] min_half_gap_o,
  output logic                   last_result_o
);

  // Configuration registers.
  logic [RadW-1:0]  inflate_q;
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflate_q <= '0;
      gain_q    <= GainW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INFLATE: inflate_q <= cfg_data_i[RadW-1:0];
        REG_GAIN:    gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  sod_state_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] n_q;
  logic [IdxW-1:0] i_q;
  logic [CntW-1:0] j_q;
  logic [1:0]      k_q;

  entry_t          pi_q;
  logic [RadW-1:0] rj_q;
  logic [RadW:0]   roi_q;
  logic [RadW:0]   roj_q;
  logic signed [PosW-1:0] c_q [3];
  logic [D2W-1:0]  d2_q;
  logic [S2W-1:0]  s2_q;
  logic [RootW-1:0] dq_q;
  logic [15:0]     q_q;
  logic [15:0]     p_q;
  logic [31:0]     prod_q;
  logic [39:0]     f_q;
  logic [NumW-1:0] num_q;
  logic signed [AccW-1:0] acc_q [3];
  logic signed [OutW-1:0] gap_q;

  logic                   valid_q;
  logic                   last_q;
  logic signed [OutW-1:0] dx_q, dy_q, dz_q, gout_q;

  // Particle store: one synchronous memory, written while loading, read during the pass.
  entry_t          mem [MaxParticles];
  entry_t          rd_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            accept;
  logic            wr_en;

  assign accept = start_i && !busy_o;
  assign wr_en  = accept && (count_q < CntW'(MaxParticles));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= '{x: pos_x_i, y: pos_y_i, z: pos_z_i, r: radius_i};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Shared arithmetic units.
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  sod_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sod_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // Combinational helpers of the pair evaluation.
  logic signed [31:0] sq_s;
  logic [RadW+1:0]    s_sum;
  logic [S2W-1:0]     s2_diff;
  logic [RadW-1:0]    rdiv;
  logic [PosW-1:0]    mag;
  logic [39:0]        fnum;
  logic [49:0]        pnum;
  logic [55:0]        cnum;
  logic signed [17:0] hg_raw;
  logic signed [17:0] hg_half;
  logic signed [OutW-1:0] hg_ext;
  logic               skip_j;
  logic               pair_end;
  logic               is_last;
  logic signed [AccW-1:0] m_ext;

  always_comb begin
    sq_s    = c_q[k_q] * c_q[k_q];
    s_sum   = {1'b0, roi_q} + {1'b0, roj_q};
    s2_diff = s2_q - {2'b00, d2_q};
    rdiv    = (pi_q.r != '0) ? pi_q.r : RadW'(1);
    mag     = c_q[k_q][PosW-1] ? PosW'(~c_q[k_q] + 1'b1) : PosW'(c_q[k_q]);
    fnum    = gain_q * p_q;
    pnum    = {prod_q, 2'b00} * q_q;
    cnum    = f_q * mag;
    hg_raw  = $signed({2'b00, dq_q}) - $signed({3'b000, pi_q.r}) - $signed({3'b000, rj_q});
    hg_half = hg_raw >>> 1;
    hg_ext  = {{(OutW-18){hg_half[17]}}, hg_half};
    skip_j  = (j_q[IdxW-1:0] == i_q);
    is_last = ((CntW'(i_q) + 1'b1) == n_q);
    m_ext   = $signed({{(AccW-NumW){1'b0}}, div_rsp.quo});
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && last_particle_i) state_d = ST_RD_I;
      ST_RD_I: state_d = ST_LD_I;
      ST_LD_I: state_d = ST_RD_J;
      ST_RD_J: begin
        if (j_q == n_q) begin
          state_d = ST_EMIT;
        end else if (!skip_j) begin
          state_d = ST_LD_J;
        end
      end
      ST_LD_J: state_d = ST_D2;
      ST_D2:   if (k_q == 2'd2) state_d = ST_S2;
      ST_S2:   state_d = ST_TEST;
      ST_TEST: state_d = ({2'b00, d2_q} > s2_q) ? ST_RD_J : ST_SQRT;
      ST_SQRT: if (sq_rsp.done) state_d = ST_GAP;
      ST_GAP:  state_d = (d2_q == '0) ? ST_RD_J : ST_DIVQ;
      ST_DIVQ: if (div_rsp.done) state_d = ST_MULP;
      ST_MULP: state_d = ST_MULN;
      ST_MULN: state_d = ST_DIVP;
      ST_DIVP: if (div_rsp.done) state_d = ST_MULF;
      ST_MULF: state_d = ST_DIVF;
      ST_DIVF: if (div_rsp.done) state_d = ST_MULC;
      ST_MULC: state_d = ST_DIVC;
      ST_DIVC: begin
        if (div_rsp.done) state_d = (k_q == 2'd2) ? ST_RD_J : ST_MULC;
      end
      ST_EMIT: state_d = is_last ? ST_IDLE : ST_RD_I;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    rd_en       = 1'b0;
    rd_addr     = i_q;
    div_req.go  = 1'b0;
    div_req.num = num_q;
    div_req.den = s2_q;
    sq_req.go   = 1'b0;
    sq_req.rad  = d2_q;
    pair_end    = 1'b0;
    case (state_q)
      ST_RD_I: rd_en = 1'b1;
      ST_RD_J: begin
        rd_addr = j_q[IdxW-1:0];
        rd_en   = (j_q != n_q) && !skip_j;
        pair_end = (j_q != n_q) && skip_j;
      end
      ST_TEST: pair_end = ({2'b00, d2_q} > s2_q);
      ST_SQRT: sq_req.go = !sq_rsp.done;
      ST_GAP:  pair_end = (d2_q == '0);
      ST_DIVQ: begin
        div_req.go  = !div_rsp.done;
        div_req.num = {{(NumW-S2W-16){1'b0}}, s2_diff, 16'h0000};
      end
      ST_DIVP: div_req.go = !div_rsp.done;
      ST_DIVF: begin
        div_req.go  = !div_rsp.done;
        div_req.den = {{(DenW-RadW){1'b0}}, rdiv};
      end
      ST_DIVC: begin
        div_req.go  = !div_rsp.done;
        div_req.den = {{(DenW-RootW){1'b0}}, dq_q};
        pair_end    = div_rsp.done && (k_q == 2'd2);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      gap_q   <= GapInit;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (accept) begin
        if (last_particle_i) begin
          n_q     <= wr_en ? count_q + 1'b1 : count_q;
          count_q <= '0;
          i_q     <= '0;
        end else if (wr_en) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (pair_end) j_q <= j_q + 1'b1;
      case (state_q)
        ST_LD_I: j_q <= '0;
        ST_LD_J: k_q <= '0;
        ST_D2:   k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
        ST_GAP:  if (hg_ext < gap_q) gap_q <= hg_ext;
        ST_MULF: k_q <= '0;
        ST_DIVC: if (div_rsp.done) k_q <= k_q + 1'b1;
        ST_EMIT: begin
          valid_q <= 1'b1;
          i_q     <= i_q + 1'b1;
          if (is_last) gap_q <= GapInit;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RD_I: begin
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
      end
      ST_LD_I: begin
        pi_q  <= rd_q;
        roi_q <= {1'b0, rd_q.r} + {1'b0, inflate_q};
      end
      ST_LD_J: begin
        c_q[0] <= $signed(pi_q.x - rd_q.x);
        c_q[1] <= $signed(pi_q.y - rd_q.y);
        c_q[2] <= $signed(pi_q.z - rd_q.z);
        rj_q   <= rd_q.r;
        roj_q  <= {1'b0, rd_q.r} + {1'b0, inflate_q};
        d2_q   <= '0;
      end
      ST_D2:   d2_q <= d2_q + D2W'($unsigned(sq_s));
      ST_S2:   s2_q <= s_sum * s_sum;
      ST_SQRT: if (sq_rsp.done) dq_q <= sq_rsp.root;
      ST_DIVQ: if (div_rsp.done) q_q <= div_rsp.quo[15:0];
      ST_MULP: prod_q <= roi_q * roj_q;
      ST_MULN: num_q <= {{(NumW-50){1'b0}}, pnum};
      ST_DIVP: if (div_rsp.done) p_q <= div_rsp.quo[15:0];
      ST_MULF: num_q <= {{(NumW-40){1'b0}}, fnum};
      ST_DIVF: if (div_rsp.done) f_q <= div_rsp.quo[39:0];
      ST_MULC: num_q <= cnum;
      ST_DIVC: begin
        if (div_rsp.done) begin
          acc_q[k_q] <= c_q[k_q][PosW-1] ? acc_q[k_q] - m_ext : acc_q[k_q] + m_ext;
        end
      end
      ST_EMIT: begin
        dx_q   <= sat32(acc_q[0]);
        dy_q   <= sat32(acc_q[1]);
        dz_q   <= sat32(acc_q[2]);
        gout_q <= is_last ? gap_q : '0;
        last_q <= is_last;
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign disp_x_o       = dx_q;
  assign disp_y_o       = dy_q;
  assign disp_z_o       = dz_q;
  assign min_half_gap_o = gout_q;
  assign last_result_o  = last_q;

  // The pass always ends with the gap minimum back at its start value.
  a_gap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> gap_q == GapInit)
    else $error("gap minimum not restored while idle");

  // Two results never come on adjacent cycles.
  a_no_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results on adjacent cycles");

  // The half gap field is only carried on the final result.
  a_gap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> min_half_gap_o == '0)
    else $error("half gap on a result that is not last");

  // The fill count never passes the store depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxParticles))
    else $error("particle count beyond store depth");

endmodule

// ===== hw/rtl/sod_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module sod_div import sod_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntBits = $clog2(NumW);

  logic [DenW-1:0]    rem_q;
  logic [NumW-1:0]    quo_q;
  logic [DenW-1:0]    den_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DenW:0]      rem_sh;
  logic [DenW:0]      rem_sub;
  logic               qbit;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.go) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.go) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== hw/rtl/sod_isqrt.sv =====
// Integer square root that retires two radicand bits per cycle.
module sod_isqrt import sod_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  localparam int Steps   = D2W / 2;
  localparam int CntBits = $clog2(Steps);

  logic [D2W-1:0]     v_q;
  logic [D2W-1:0]     res_q;
  logic [D2W-1:0]     bit_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [D2W:0]       trial;
  logic               take;

  always_comb begin
    trial = {1'b0, res_q} + {1'b0, bit_q};
    take  = ({1'b0, v_q} >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.go) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.go) begin
      v_q   <= req_i.rad;
      res_q <= '0;
      bit_q <= D2W'(1) << (D2W - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q   <= v_q - trial[D2W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];

endmodule
